// ----- src/jmso_pkg.sv -----
// ----------------------------------------------------------------------------
// jmso_pkg: shared types and constants of the JPEG marker segment parser
// Holds the parser phase encoding, result status codes and marker constants.
// ----------------------------------------------------------------------------
package jmso_pkg;

  localparam int unsigned OUT_OFFSET_BITS = 32;
  localparam int unsigned STATUS_BITS     = 2;
  localparam int unsigned SKIP_BITS       = 16;

  localparam logic [7:0] MARKER_PREFIX = 8'hff;
  localparam logic [7:0] SOI_CODE      = 8'hd8;
  localparam logic [7:0] APP_FIRST     = 8'he0;
  localparam logic [7:0] APP_LAST      = 8'hef;
  localparam logic [7:0] COM_CODE      = 8'hfe;
  localparam logic [7:0] DQT_CODE      = 8'hdb;
  localparam logic [15:0] LEN_MIN      = 16'd2;

  typedef enum logic [2:0] {
    PH_SOI0 = 3'd0,
    PH_SOI1 = 3'd1,
    PH_MK0  = 3'd2,
    PH_MK1  = 3'd3,
    PH_LENH = 3'd4,
    PH_LENL = 3'd5,
    PH_SKIP = 3'd6
  } phase_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_JPEG  = 2'd1,
    ST_TRUNCATED = 2'd2,
    ST_BAD_LEN   = 2'd3
  } status_e;

  // Segments that carry only metadata and get skipped.
  function automatic logic is_metadata(input logic [7:0] code);
    return ((code >= APP_FIRST) && (code <= APP_LAST)) ||
           (code == COM_CODE) || (code == DQT_CODE);
  endfunction

endpackage

// ----- src/jpeg_metadata_skip_offset.sv -----
// ----------------------------------------------------------------------------
// jpeg_metadata_skip_offset: JPEG marker segment parser
// Walks marker segments of a JPEG byte stream and reports the offset of the
// first marker that is not metadata, or an error status.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one file byte per transaction (data_byte_i, last_byte_i),
//   taken at a clock edge with in_valid_i high and in_stall_o low. The last
//   byte of each file carries last_byte_i = 1.
//   Output channel: at most one result per file (image_offset_o, status_o),
//   handed over at an edge with out_valid_o high and out_stall_i low.
//   Status: found, not JPEG, truncated, bad segment length; image_offset_o is
//   zero unless status is found.
// Timing:
//   One byte per cycle while in_stall_o is low. Each byte needs compares,
//   one 16-bit decrement and one offset increment in a single combinational
//   pass from the parser state to the result register, which is loaded at
//   the edge that takes the deciding byte; the result shows in the next cycle.
//   While a result waits under out_stall_i, in_stall_o is high and no byte
//   is taken.
// Reset:
//   rst_ni clears the parser to expect the start-of-image bytes at offset 0
//   and empties the output register. After a decision the parser drops bytes
//   up to the one marked last, then rearms for the next file.
// ----------------------------------------------------------------------------
module jpeg_metadata_skip_offset #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [7:0]                           data_byte_i,
  input  logic                                 last_byte_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [jmso_pkg::OUT_OFFSET_BITS-1:0] image_offset_o,
  output logic [jmso_pkg::STATUS_BITS-1:0]     status_o
);
  import jmso_pkg::*;

  // Parser state.
  phase_e                 phase_q, phase_d;
  logic [OFFSET_BITS-1:0] byte_pos_q, byte_pos_d;
  logic [SKIP_BITS-1:0]   skip_q, skip_d;
  logic [OFFSET_BITS-1:0] marker_pos_q, marker_pos_d;
  logic [7:0]             marker_code_q, marker_code_d;
  logic [7:0]             len_high_q, len_high_d;
  logic                   decided_q, decided_d;

  // Output register.
  logic                       out_valid_q, out_valid_d;
  logic [OUT_OFFSET_BITS-1:0] offset_q, offset_d;
  status_e                    status_q, status_d;

  logic           in_fire;
  logic           res_fire;
  logic           rearm;
  logic [15:0]    seg_len;
  logic [15:0]    skip_len;

  // Stall only while a result is held and the receiver stalls it.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign seg_len    = {len_high_q, data_byte_i};
  assign skip_len   = seg_len - LEN_MIN;

  always_comb begin
    phase_d       = phase_q;
    byte_pos_d    = byte_pos_q;
    skip_d        = skip_q;
    marker_pos_d  = marker_pos_q;
    marker_code_d = marker_code_q;
    len_high_d    = len_high_q;
    decided_d     = decided_q;
    res_fire      = 1'b0;
    rearm         = 1'b0;
    status_d      = ST_FOUND;
    offset_d      = '0;

    if (in_fire) begin
      if (decided_q) begin
        // Drop bytes until the end of the file.
        rearm = last_byte_i;
      end else begin
        byte_pos_d = byte_pos_q + 1'b1;
        case (phase_q)
          PH_SOI0: begin
            if (data_byte_i != MARKER_PREFIX) begin
              res_fire = 1'b1;
              status_d = ST_NOT_JPEG;
            end else begin
              phase_d = PH_SOI1;
            end
          end
          PH_SOI1: begin
            if (data_byte_i != SOI_CODE) begin
              res_fire = 1'b1;
              status_d = ST_NOT_JPEG;
            end else begin
              phase_d = PH_MK0;
            end
          end
          PH_MK0: begin
            marker_pos_d  = byte_pos_q;
            marker_code_d = data_byte_i;
            phase_d       = PH_MK1;
          end
          PH_MK1: begin
            // A window without the FF prefix is skipped like a comment.
            marker_code_d = (marker_code_q == MARKER_PREFIX) ? data_byte_i : COM_CODE;
            phase_d       = PH_LENH;
          end
          PH_LENH: begin
            len_high_d = data_byte_i;
            phase_d    = PH_LENL;
          end
          PH_LENL: begin
            if (!is_metadata(marker_code_q)) begin
              res_fire = 1'b1;
              status_d = ST_FOUND;
              offset_d = OUT_OFFSET_BITS'(marker_pos_q);
            end else if (seg_len < LEN_MIN) begin
              res_fire = 1'b1;
              status_d = ST_BAD_LEN;
            end else begin
              skip_d  = skip_len;
              phase_d = (skip_len != '0) ? PH_SKIP : PH_MK0;
            end
          end
          PH_SKIP: begin
            skip_d = skip_q - 1'b1;
            if (skip_q == SKIP_BITS'(1)) begin
              phase_d = PH_MK0;
            end
          end
          default: begin
            phase_d = PH_MK0;
          end
        endcase

        if (!res_fire && last_byte_i) begin
          res_fire = 1'b1;
          status_d = ST_TRUNCATED;
        end
        if (res_fire) begin
          if (last_byte_i) begin
            rearm = 1'b1;
          end else begin
            decided_d = 1'b1;
          end
        end
      end
    end

    if (rearm) begin
      phase_d    = PH_SOI0;
      byte_pos_d = '0;
      decided_d  = 1'b0;
    end

    out_valid_d = res_fire | (out_valid_q & out_stall_i);
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SOI0;
      byte_pos_q  <= '0;
      decided_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      byte_pos_q  <= byte_pos_d;
      decided_q   <= decided_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Segment bookkeeping; each field is written before it is read.
  always_ff @(posedge clk_i) begin
    skip_q        <= skip_d;
    marker_pos_q  <= marker_pos_d;
    marker_code_q <= marker_code_d;
    len_high_q    <= len_high_d;
  end

  // Load the result register only when a new result is produced.
  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      offset_q <= offset_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign image_offset_o = offset_q;
  assign status_o       = status_q;

endmodule

// ----- src/jmso_checker.sv -----
// ----------------------------------------------------------------------------
// jmso_checker: port-level checks of the JPEG marker segment parser
// Watches the top-level ports over time and flags broken behavior.
// ----------------------------------------------------------------------------
module jmso_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic [jmso_pkg::OUT_OFFSET_BITS-1:0] image_offset_o,
  input logic [jmso_pkg::STATUS_BITS-1:0]     status_o
);
  import jmso_pkg::*;

  // Hold a stalled result unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(image_offset_o) && $stable(status_o))
    else $error("stalled result changed");

  // Report a nonzero offset only with a found status.
  a_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_FOUND) |-> image_offset_o == '0)
    else $error("offset nonzero on error status");

  // Stall the input only behind a held, stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // Produce no result without an accepted byte.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && out_stall_i) && !(in_valid_i && !in_stall_o) |=> !out_valid_o)
    else $error("result appeared without an input transaction");

endmodule

bind jpeg_metadata_skip_offset jmso_checker u_jmso_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .image_offset_o (image_offset_o),
  .status_o       (status_o)
);
